// ===== rtl/serpentine_pan_tilt_scan_controller_core_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the scan controller
// Each macro expands to one labeled concurrent assertion clocked on clock and
// disabled during reset.
// ---------------------------------------------------------------------------
`ifndef SERPENTINE_PAN_TILT_SCAN_CONTROLLER_CORE_DEFINES_SVH
`define SERPENTINE_PAN_TILT_SCAN_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication
`define SPTSC_ASSERT_NOW(label, ante, cons, msg) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
   else $error(msg);

// next-cycle implication
`define SPTSC_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
   else $error(msg);

`endif

// ===== rtl/sptsc_pkg.sv =====
// ---------------------------------------------------------------------------
// Scan controller package
// Shared types, register indexes, record kinds and reset values.
// ---------------------------------------------------------------------------
package sptsc_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PAN_MIN       = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PAN_MAX       = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TILT_MIN      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TILT_MAX      = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PARK_POSITION = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_INTERVAL = 3'd5;

   localparam logic [7:0]  RST_PAN_MIN       = 8'd30;
   localparam logic [7:0]  RST_PAN_MAX       = 8'd70;
   localparam logic [7:0]  RST_TILT_MIN      = 8'd85;
   localparam logic [7:0]  RST_TILT_MAX      = 8'd100;
   localparam logic [7:0]  RST_PARK_POSITION = 8'd90;
   localparam logic [15:0] RST_STEP_INTERVAL = 16'd100;

   localparam logic [7:0]  START_BYTE     = 8'h73;
   localparam logic [15:0] ELAPSED_CEIL   = 16'hFFFF;

   localparam logic ACTION_TICK = 1'b0;
   localparam logic ACTION_BYTE = 1'b1;

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_START  = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;
   localparam logic [1:0] KIND_PARKED = 2'd3;

   typedef struct packed {
      logic [7:0]  pan_min;
      logic [7:0]  pan_max;
      logic [7:0]  tilt_min;
      logic [7:0]  tilt_max;
      logic [7:0]  park_position;
      logic [15:0] step_interval;
   } cfg_type;

   typedef struct packed {
      logic [7:0] pan_position;
      logic [7:0] tilt_position;
      logic [1:0] record_kind;
      logic       last;
   } rec_type;

   typedef struct packed {
      logic [1:0] count;
      rec_type    rec0;
      rec_type    rec1;
   } pair_type;

endpackage

// ===== rtl/sptsc_ifs.sv =====
// ---------------------------------------------------------------------------
// Scan controller channel interfaces
// Item channel and result channel, each with valid/ready and payload.
// ---------------------------------------------------------------------------
interface sptsc_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] command_byte;

   modport source (output valid, output action, output command_byte, input ready);
   modport sink   (input valid, input action, input command_byte, output ready);
endinterface

interface sptsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pan_position;
   logic [7:0] tilt_position;
   logic [1:0] record_kind;
   logic       last;

   modport source (output valid, output pan_position, output tilt_position,
                   output record_kind, output last, input ready);
   modport sink   (input valid, input pan_position, input tilt_position,
                   input record_kind, input last, output ready);
endinterface

// ===== rtl/sptsc_seq.sv =====
// ---------------------------------------------------------------------------
// Scan sequencer
// Holds the scan state and turns one item into up to two result records.
// ---------------------------------------------------------------------------
module sptsc_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic               action,
   input  logic [7:0]         command_byte,
   input  sptsc_pkg::cfg_type cfg,
   output sptsc_pkg::pair_type pair
);
   import sptsc_pkg::*;

   typedef enum logic [1:0] {
      MODE_PARK_PENDING = 2'd0,
      MODE_STOPPED      = 2'd1,
      MODE_RUNNING      = 2'd2
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [7:0]  pan_ff, pan_in;
   logic [7:0]  tilt_ff, tilt_in;
   logic        down_ff, down_in;
   logic [15:0] elapsed_ff, elapsed_in;

   logic [15:0] elapsed_inc;
   logic [7:0]  pan_step;
   logic [7:0]  tilt_step;

   always_comb begin
      mode_in    = mode_ff;
      pan_in     = pan_ff;
      tilt_in    = tilt_ff;
      down_in    = down_ff;
      elapsed_in = elapsed_ff;
      pair       = '0;

      elapsed_inc = (elapsed_ff == ELAPSED_CEIL) ? elapsed_ff : elapsed_ff + 16'd1;
      pan_step    = down_ff ? pan_ff - 8'd1 : pan_ff + 8'd1;
      tilt_step   = tilt_ff + 8'd1;

      case (mode_ff)
         MODE_PARK_PENDING: begin
            pair.count = 2'd1;
            pair.rec0  = '{cfg.park_position, cfg.park_position, KIND_PARKED, 1'b1};
            mode_in    = MODE_STOPPED;
         end
         MODE_RUNNING: begin
            if (action == ACTION_TICK) begin
               elapsed_in = elapsed_inc;
               if (elapsed_inc > cfg.step_interval) begin
                  elapsed_in = '0;
                  pan_in     = pan_step;
                  pair.count = 2'd1;
                  pair.rec0  = '{pan_step, tilt_ff, KIND_SAMPLE, 1'b1};
                  if (pan_step >= cfg.pan_max || pan_step <= cfg.pan_min) begin
                     down_in        = !down_ff;
                     tilt_in        = tilt_step;
                     pair.count     = 2'd2;
                     pair.rec0.last = 1'b0;
                     if (tilt_step > cfg.tilt_max) begin
                        pair.rec1 = '{cfg.park_position, cfg.park_position,
                                      KIND_DONE, 1'b1};
                        mode_in   = MODE_STOPPED;
                     end else begin
                        pair.rec1 = '{pan_step, tilt_step, KIND_SAMPLE, 1'b1};
                     end
                  end
               end
            end
         end
         default: begin
            if (action == ACTION_BYTE && command_byte == START_BYTE) begin
               pan_in     = cfg.pan_min;
               tilt_in    = cfg.tilt_min;
               down_in    = 1'b0;
               elapsed_in = '0;
               mode_in    = MODE_RUNNING;
               pair.count = 2'd1;
               pair.rec0  = '{cfg.pan_min, cfg.tilt_min, KIND_START, 1'b1};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_PARK_PENDING;
         pan_ff     <= '0;
         tilt_ff    <= '0;
         down_ff    <= 1'b0;
         elapsed_ff <= '0;
      end else if (fire) begin
         mode_ff    <= mode_in;
         pan_ff     <= pan_in;
         tilt_ff    <= tilt_in;
         down_ff    <= down_in;
         elapsed_ff <= elapsed_in;
      end
   end

endmodule

// ===== rtl/sptsc_out_buf.sv =====
// ---------------------------------------------------------------------------
// Result buffer
// Holds the records of one item and presents them in order on the result
// channel.
// ---------------------------------------------------------------------------
module sptsc_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  sptsc_pkg::pair_type pair,
   output logic                free,
   sptsc_rsp_if.source         rsp_chan
);
   import sptsc_pkg::*;

   logic [1:0] count_ff, count_in;
   rec_type    rec0_ff, rec0_in;
   rec_type    rec1_ff, rec1_in;
   logic       take;

   assign take = rsp_chan.valid && rsp_chan.ready;
   assign free = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp_chan.ready);

   always_comb begin
      count_in = count_ff;
      rec0_in  = rec0_ff;
      rec1_in  = rec1_ff;
      if (load) begin
         count_in = pair.count;
         rec0_in  = pair.rec0;
         rec1_in  = pair.rec1;
      end else if (take) begin
         count_in = count_ff - 2'd1;
         rec0_in  = rec1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      rec0_ff <= rec0_in;
      rec1_ff <= rec1_in;
   end

   assign rsp_chan.valid         = (count_ff != 2'd0);
   assign rsp_chan.pan_position  = rec0_ff.pan_position;
   assign rsp_chan.tilt_position = rec0_ff.tilt_position;
   assign rsp_chan.record_kind   = rec0_ff.record_kind;
   assign rsp_chan.last          = rec0_ff.last;

endmodule

// ===== rtl/serpentine_pan_tilt_scan_controller_core.sv =====
// ---------------------------------------------------------------------------
// Serpentine pan/tilt scan controller
// Steps a pan/tilt pair over a serpentine raster on millisecond ticks and
// reports start, sample, completion and park records.
// ---------------------------------------------------------------------------
// An item (tick or command byte) is taken into an input register, processed
// by the sequencer once the result buffer is free and its records land in a
// two-entry result buffer. The block takes one item per cycle while each item
// yields at most one record and the result side keeps up; an item that yields
// two records (a sample at a pan bound) holds off the next item until its
// first record has been taken. Register writes apply at once and are meant
// for idle periods.
`include "serpentine_pan_tilt_scan_controller_core_defines.svh"

module serpentine_pan_tilt_scan_controller_core (
   input  logic                                   clock,
   input  logic                                   reset,
   sptsc_req_if.sink                              req_chan,
   sptsc_rsp_if.source                            rsp_chan,
   input  logic                                   csr_we,
   input  logic [sptsc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [sptsc_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import sptsc_pkg::*;

   cfg_type    cfg_ff;
   logic       s1_valid_ff;
   logic       s1_action_ff;
   logic [7:0] s1_byte_ff;
   logic       free;
   logic       fire;
   pair_type   pair;

   assign fire           = s1_valid_ff && free;
   assign req_chan.ready = !s1_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pan_min       <= RST_PAN_MIN;
         cfg_ff.pan_max       <= RST_PAN_MAX;
         cfg_ff.tilt_min      <= RST_TILT_MIN;
         cfg_ff.tilt_max      <= RST_TILT_MAX;
         cfg_ff.park_position <= RST_PARK_POSITION;
         cfg_ff.step_interval <= RST_STEP_INTERVAL;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PAN_MIN:       cfg_ff.pan_min       <= csr_wdata[7:0];
            CSR_PAN_MAX:       cfg_ff.pan_max       <= csr_wdata[7:0];
            CSR_TILT_MIN:      cfg_ff.tilt_min      <= csr_wdata[7:0];
            CSR_TILT_MAX:      cfg_ff.tilt_max      <= csr_wdata[7:0];
            CSR_PARK_POSITION: cfg_ff.park_position <= csr_wdata[7:0];
            CSR_STEP_INTERVAL: cfg_ff.step_interval <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
      if (req_chan.valid && req_chan.ready) begin
         s1_action_ff <= req_chan.action;
         s1_byte_ff   <= req_chan.command_byte;
      end
   end

   sptsc_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .action       (s1_action_ff),
      .command_byte (s1_byte_ff),
      .cfg          (cfg_ff),
      .pair         (pair)
   );

   sptsc_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .load     (fire),
      .pair     (pair),
      .free     (free),
      .rsp_chan (rsp_chan)
   );

   `SPTSC_ASSERT_NOW(a_single_kinds_last, rsp_chan.valid && (rsp_chan.record_kind == KIND_START || rsp_chan.record_kind == KIND_DONE || rsp_chan.record_kind == KIND_PARKED), rsp_chan.last, "start, done and park records must close their item")
   `SPTSC_ASSERT_NEXT(a_pair_first_shown, fire && pair.count == 2'd2, rsp_chan.valid && !rsp_chan.last, "first record of a pair not presented")
   `SPTSC_ASSERT_NEXT(a_pair_second_follows, rsp_chan.valid && rsp_chan.ready && !rsp_chan.last, rsp_chan.valid && rsp_chan.last, "second record of a pair missing")

endmodule
